### design/nsx_pkg.sv
// Shared types and constants for the normalized sliding cross-correlator.
package nsx_pkg;

  localparam int TAP_E_W   = 42;
  localparam int TAP_IDX_W = 10;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 64;

  localparam logic       FUNC_LOAD      = 1'b0;
  localparam logic       FUNC_PUSH      = 1'b1;
  localparam logic [0:0] REG_TAP_ENERGY = 1'b0;

  typedef struct packed {
    logic in_rdy;
    logic rd_old;
    logic sq;
    logic upd;
    logic mac_init;
    logic mac_issue;
    logic zero_out;
    logic mul_init;
    logic mul_step;
    logic sq_step;
    logic div_init;
    logic div_step;
    logic div_store;
    logic div_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic push_acc;
    logic full;
    logic ezero;
    logic out_busy;
  } sts_t;

endpackage

### design/nsx_ctrl.sv
// Sequencing state machine for the correlator datapath.
module nsx_ctrl #(
  parameter int WINDOW      = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nsx_pkg::sts_t sts,
  output nsx_pkg::cmd_t cmd
);

  localparam int TEW = nsx_pkg::TAP_E_W;
  localparam int EW  = 2 * SAMPLE_BITS + $clog2(WINDOW);
  localparam int PW0 = EW + TEW;
  localparam int PW  = PW0 + PW0 % 2;
  localparam int RW  = PW / 2;
  localparam int DW  = 2 * SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int F   = SAMPLE_BITS - 1;
  localparam int NW0 = (DW + F + 1 > RW) ? DW + F + 1 : RW;
  localparam int NW  = NW0 + 1;
  localparam int CW  = $clog2(WINDOW + 256);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDOLD = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_MAC   = 4'd5;
  localparam logic [3:0] S_ZCHK  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DIVLD = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DIVST = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.push_acc) state_nxt = S_RDOLD;
      end
      S_RDOLD: begin
        cmd.rd_old = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.full) begin
          cmd.mac_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_MAC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac_issue = (cnt_r < CW'(WINDOW));
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(WINDOW + 1)) state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        cnt_nxt = '0;
        if (sts.ezero) begin
          cmd.zero_out = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.mul_init = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(TEW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          sel_nxt   = 1'b0;
          state_nxt = S_DIVLD;
        end
      end
      S_DIVLD: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) state_nxt = S_DIVST;
      end
      S_DIVST: begin
        cmd.div_store = 1'b1;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_DIVLD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### design/nsx_dp.sv
// Datapath: sample and tap memories, energy, complex MAC, sqrt and divider.
module nsx_dp #(
  parameter int WINDOW      = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nsx_pkg::cmd_t                       cmd,
  output nsx_pkg::sts_t                       sts,
  input  logic [nsx_pkg::TAP_E_W-1:0]         tap_energy,
  input  logic                                in_valid,
  input  logic                                in_func,
  input  logic [nsx_pkg::TAP_IDX_W-1:0]       in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]       in_value_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_value_im,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_corr_re,
  output logic signed [SAMPLE_BITS-1:0]       out_corr_im,
  output logic                                out_zero_energy
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(WINDOW);
  localparam int FCW = $clog2(WINDOW + 1);
  localparam int TEW = nsx_pkg::TAP_E_W;
  localparam int EW  = 2 * SB + $clog2(WINDOW);
  localparam int PW0 = EW + TEW;
  localparam int PW  = PW0 + PW0 % 2;
  localparam int RW  = PW / 2;
  localparam int DW  = 2 * SB + $clog2(WINDOW) + 1;
  localparam int PRW = 2 * SB + 1;
  localparam int F   = SB - 1;
  localparam int NW0 = (DW + F + 1 > RW) ? DW + F + 1 : RW;
  localparam int NW  = NW0 + 1;
  localparam int QW  = F + 2;

  logic [2*SB-1:0] hist_mem [WINDOW];
  logic [2*SB-1:0] tap_mem  [WINDOW];

  logic                 accept;
  logic                 tap_we;
  logic [AW-1:0]        tap_waddr;
  logic [AW-1:0]        hist_raddr;
  logic [2*SB-1:0]      hist_q_r, tap_q_r;
  logic signed [SB-1:0] new_re_r, new_im_r;
  logic [AW-1:0]        wp_r, pos_r, k_r;
  logic [FCW-1:0]       fill_r;
  logic [EW-1:0]        energy_r;
  logic [2*SB-1:0]      old_e_r, new_e_r;
  logic                 v1_r, v2_r;
  logic signed [PRW-1:0] prod_re_r, prod_im_r;
  logic signed [DW-1:0]  acc_re_r, acc_im_r;
  logic [PW-1:0]        p_r;
  logic [TEW-1:0]       b_r;
  logic [RW+1:0]        rem_r;
  logic [RW-1:0]        root_r;
  logic [NW-1:0]        num_r;
  logic [RW:0]          drem_r;
  logic [QW-1:0]        q_r;
  logic                 ovf_r, neg_r;
  logic signed [SB-1:0] res_re_r, res_im_r;
  logic                 res_zero_r;
  logic                 out_valid_r;

  logic signed [SB-1:0]   ore, oim, hr, hi, tr, ti;
  logic signed [2*SB-1:0] ore2, oim2, nre2, nim2, p_rr, p_ii, p_ri, p_ir;
  logic [RW+1:0]          rem_sh, trial;
  logic [RW+1:0]          dr2;
  logic [RW:0]            den;
  logic signed [DW-1:0]   acc_sel;
  logic [DW-1:0]          mag;
  logic [QW-1:0]          limit;
  logic signed [SB-1:0]   sat_val;

  assign accept    = in_valid && cmd.in_rdy;
  assign tap_waddr = AW'(in_tap_index);
  assign tap_we    = accept && (in_func == nsx_pkg::FUNC_LOAD) &&
                     (32'(in_tap_index) < WINDOW);
  assign hist_raddr = cmd.rd_old ? wp_r : pos_r;

  always_ff @(posedge clk) begin
    if (tap_we) tap_mem[tap_waddr] <= {in_value_im, in_value_re};
    if (cmd.mac_issue) tap_q_r <= tap_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) hist_mem[wp_r] <= {new_im_r, new_re_r};
    if (cmd.rd_old || cmd.mac_issue) hist_q_r <= hist_mem[hist_raddr];
  end

  // never-written history entries read as zero until the window has filled
  assign ore = (fill_r == FCW'(WINDOW)) ? $signed(hist_q_r[SB-1:0]) : '0;
  assign oim = (fill_r == FCW'(WINDOW)) ? $signed(hist_q_r[2*SB-1:SB]) : '0;
  assign ore2 = ore * ore;
  assign oim2 = oim * oim;
  assign nre2 = new_re_r * new_re_r;
  assign nim2 = new_im_r * new_im_r;

  assign hr = $signed(hist_q_r[SB-1:0]);
  assign hi = $signed(hist_q_r[2*SB-1:SB]);
  assign tr = $signed(tap_q_r[SB-1:0]);
  assign ti = $signed(tap_q_r[2*SB-1:SB]);
  assign p_rr = hr * tr;
  assign p_ii = hi * ti;
  assign p_ri = hr * ti;
  assign p_ir = hi * tr;

  assign rem_sh = {rem_r[RW-1:0], p_r[PW-1:PW-2]};
  assign trial  = {root_r, 2'b01};
  assign den    = {root_r, 1'b0};
  assign dr2    = {drem_r, num_r[NW-1]};
  assign acc_sel = cmd.div_sel ? acc_im_r : acc_re_r;
  assign mag     = acc_sel[DW-1] ? DW'(-acc_sel) : DW'(acc_sel);
  assign limit   = QW'(1) << F;

  always_comb begin
    if (neg_r) begin
      if (ovf_r || q_r > limit) sat_val = SB'(-(limit));
      else sat_val = SB'(~q_r + 1'b1);
    end else begin
      if (ovf_r || q_r >= limit) sat_val = SB'(limit - 1'b1);
      else sat_val = SB'(q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      energy_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
      if (cmd.upd) begin
        energy_r <= energy_r - EW'(old_e_r) + EW'(new_e_r);
        wp_r     <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != FCW'(WINDOW)) fill_r <= fill_r + 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      new_re_r <= in_value_re;
      new_im_r <= in_value_im;
    end
    if (cmd.sq) begin
      old_e_r <= $unsigned(ore2) + $unsigned(oim2);
      new_e_r <= $unsigned(nre2) + $unsigned(nim2);
    end
    if (cmd.mac_init) begin
      pos_r    <= wp_r;
      k_r      <= '0;
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else begin
      if (cmd.mac_issue) begin
        pos_r <= (pos_r == AW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
        k_r   <= k_r + 1'b1;
      end
      if (v2_r) begin
        acc_re_r <= acc_re_r + DW'(prod_re_r);
        acc_im_r <= acc_im_r + DW'(prod_im_r);
      end
    end
    if (v1_r) begin
      prod_re_r <= PRW'(p_rr) - PRW'(p_ii);
      prod_im_r <= PRW'(p_ri) + PRW'(p_ir);
    end
    if (cmd.mul_init) begin
      p_r    <= '0;
      b_r    <= tap_energy;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.mul_step) begin
      p_r <= {p_r[PW-2:0], 1'b0} + (b_r[TEW-1] ? PW'(energy_r) : '0);
      b_r <= {b_r[TEW-2:0], 1'b0};
    end else if (cmd.sq_step) begin
      p_r <= {p_r[PW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      num_r  <= NW'({mag, (F + 1)'(0)}) + NW'(root_r);
      drem_r <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      neg_r  <= acc_sel[DW-1];
    end else if (cmd.div_step) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[QW-1];
      if (dr2 >= {1'b0, den}) begin
        drem_r <= (RW + 1)'(dr2 - {1'b0, den});
        q_r    <= {q_r[QW-2:0], 1'b1};
      end else begin
        drem_r <= dr2[RW:0];
        q_r    <= {q_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.zero_out) begin
      res_re_r   <= '0;
      res_im_r   <= '0;
      res_zero_r <= 1'b1;
    end else if (cmd.div_store) begin
      res_zero_r <= 1'b0;
      if (cmd.div_sel) res_im_r <= sat_val;
      else res_re_r <= sat_val;
    end
    if (cmd.out_load) begin
      out_corr_re     <= res_re_r;
      out_corr_im     <= res_im_r;
      out_zero_energy <= res_zero_r;
    end
  end

  assign sts.push_acc = accept && (in_func == nsx_pkg::FUNC_PUSH);
  assign sts.full     = (fill_r == FCW'(WINDOW));
  assign sts.ezero    = (energy_r == '0) || (tap_energy == '0);
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FCW'(WINDOW)) else $error("fill count beyond window");
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(WINDOW - 1)) else $error("write pointer beyond window");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> root_r != '0) else $error("divide by zero root");
  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready)) else $error("result overwritten");

endmodule

### design/normalized_sliding_xcorr.sv
// Top level of the normalized sliding cross-correlator with its register port.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_func, in_tap_index, in_value_re, in_value_im
//   out     | out_valid/ out_ready | out_corr_re, out_corr_im, out_zero_energy
//   cfg     | psel, penable, pwrite| paddr, pwdata, prdata (tap_energy at 0)
//
// A tap load is written without leaving the idle state. A push steps through
// read-old, square and update before the window is full; once it is full,
// it also runs the single complex MAC over the window, the shift-add energy
// product, the bit-serial root and the shared bit-serial divider.
// rst_n is synchronous; no clearing pass. A waiting result does not block
// the next item; a stalled result holds the engine at its final state only.
module normalized_sliding_xcorr #(
  parameter int WINDOW      = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [nsx_pkg::TAP_IDX_W-1:0]       in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]       in_value_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_value_im,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_corr_re,
  output logic signed [SAMPLE_BITS-1:0]       out_corr_im,
  output logic                                out_zero_energy,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nsx_pkg::CFG_AW-1:0]          paddr,
  input  logic [nsx_pkg::CFG_DW-1:0]          pwdata,
  output logic [nsx_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  nsx_pkg::cmd_t                   cmd;
  nsx_pkg::sts_t                   sts;
  logic [nsx_pkg::TAP_E_W-1:0]     tap_energy_r;
  logic                            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[3] == nsx_pkg::REG_TAP_ENERGY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_energy_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      tap_energy_r <= pwdata[nsx_pkg::TAP_E_W-1:0];
    end
  end

  assign prdata   = reg_sel ? nsx_pkg::CFG_DW'(tap_energy_r) : '0;
  assign in_ready = cmd.in_rdy;

  nsx_ctrl #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  nsx_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .tap_energy      (tap_energy_r),
    .in_valid        (in_valid),
    .in_func         (in_func),
    .in_tap_index    (in_tap_index),
    .in_value_re     (in_value_re),
    .in_value_im     (in_value_im),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_corr_re     (out_corr_re),
    .out_corr_im     (out_corr_im),
    .out_zero_energy (out_zero_energy)
  );

endmodule

### tb/sv/normalized_sliding_xcorr_tb.sv
// Testbench for the normalized sliding cross-correlator: directed table, then random items.
module normalized_sliding_xcorr_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 1024;
  localparam logic [nsx_pkg::TAP_E_W-1:0] TAP_E_MAX = {nsx_pkg::TAP_E_W{1'b1}};

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               zero;
  } corr_t;

  typedef enum {ROW_ITEM, ROW_CFG, ROW_CFG_TAPS, ROW_LOAD_ALL, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               func;
    int                 idx;
    int                 re;
    int                 im;
    logic [63:0]        cfg;
    bit                 typed;
    corr_t              res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [nsx_pkg::TAP_IDX_W-1:0] in_tap_index = '0;
  logic signed [15:0] in_value_re = '0;
  logic signed [15:0] in_value_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_corr_re;
  logic signed [15:0] out_corr_im;
  logic out_zero_energy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [nsx_pkg::CFG_AW-1:0] paddr = '0;
  logic [nsx_pkg::CFG_DW-1:0] pwdata = '0;
  logic [nsx_pkg::CFG_DW-1:0] prdata;
  logic pready;

  normalized_sliding_xcorr u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int tap_re [WIN];
  int tap_im [WIN];
  int hist_re [WIN];
  int hist_im [WIN];
  longint unsigned win_energy;
  longint unsigned tap_energy_q;
  int wptr;
  int fill;

  corr_t corr_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  function automatic logic [63:0] root_of(input logic [127:0] p);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= p) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] scale_part(input longint d, input logic [63:0] s);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (d < 0) ? 128'(-d) : 128'(d);
    q = ((mag << 16) + {64'd0, s}) / ({64'd0, s} << 1);
    if (d < 0) begin
      if (q > 128'd32768) q = 128'd32768;
      return -16'(q);
    end
    if (q > 128'd32767) q = 128'd32767;
    return 16'(q);
  endfunction

  function automatic longint unsigned loaded_tap_energy();
    longint unsigned e;
    e = 0;
    for (int k = 0; k < WIN; k++) e += longint'(tap_re[k] * tap_re[k]) + longint'(tap_im[k] * tap_im[k]);
    return e;
  endfunction

  // Updates predictor state; returns 1 and the expected correlation when a result is due.
  function automatic bit predict_corr(input logic f, input int idx, input int re, input int im,
                                      output corr_t res);
    longint acc_re;
    longint acc_im;
    int pos;
    logic [63:0] s;
    acc_re = 0;
    acc_im = 0;
    res = '{0, 0, 0};
    if (f == nsx_pkg::FUNC_LOAD) begin
      tap_re[idx] = re;
      tap_im[idx] = im;
      return 0;
    end
    win_energy = win_energy - (longint'(hist_re[wptr] * hist_re[wptr]) +
                               longint'(hist_im[wptr] * hist_im[wptr]))
                 + (longint'(re * re) + longint'(im * im));
    hist_re[wptr] = re;
    hist_im[wptr] = im;
    wptr = (wptr + 1) % WIN;
    if (fill < WIN) fill++;
    if (fill < WIN) return 0;
    pos = wptr;
    for (int k = 0; k < WIN; k++) begin
      acc_re += longint'(hist_re[pos]) * tap_re[k] - longint'(hist_im[pos]) * tap_im[k];
      acc_im += longint'(hist_re[pos]) * tap_im[k] + longint'(hist_im[pos]) * tap_re[k];
      pos = (pos + 1) % WIN;
    end
    if (win_energy == 0 || tap_energy_q == 0) begin
      res = '{16'sd0, 16'sd0, 1'b1};
      return 1;
    end
    s = root_of({64'd0, win_energy} * {64'd0, tap_energy_q});
    res = '{scale_part(acc_re, s), scale_part(acc_im, s), 1'b0};
    return 1;
  endfunction

  task automatic send_item(input logic f, input int idx, input int re, input int im,
                           input bit typed, input corr_t typed_res);
    corr_t res;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_func <= f;
    in_tap_index <= nsx_pkg::TAP_IDX_W'(idx);
    in_value_re <= 16'(re);
    in_value_im <= 16'(im);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (predict_corr(f, idx, re, im, res)) corr_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_tap_energy(input logic [63:0] value);
    in_valid <= 1'b0;
    wait (corr_q.size() == 0);
    @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= nsx_pkg::CFG_AW'(32'(nsx_pkg::REG_TAP_ENERGY) * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tap_energy_q = value[nsx_pkg::TAP_E_W-1:0];
  endtask

  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    corr_t e;
    if (rst_n && out_valid && out_ready) begin
      if (corr_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: exp none act re=%0d im=%0d z=%0b",
                 $time, out_corr_re, out_corr_im, out_zero_energy);
      end else begin
        e = corr_q.pop_front();
        if (out_corr_re !== e.re) begin
          errors++;
          $display("%0t: corr_re exp %0d act %0d", $time, e.re, out_corr_re);
        end
        if (out_corr_im !== e.im) begin
          errors++;
          $display("%0t: corr_im exp %0d act %0d", $time, e.im, out_corr_im);
        end
        if (out_zero_energy !== e.zero) begin
          errors++;
          $display("%0t: zero_energy exp %0b act %0b", $time, e.zero, out_zero_energy);
        end
      end
    end
  end

  initial begin
    #48_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  row_t rows[$];
  corr_t none = '{0, 0, 0};
  corr_t zero_res = '{16'sd0, 16'sd0, 1'b1};

  initial begin
    int pick;
    for (int k = 0; k < WIN; k++) begin
      tap_re[k] = 0;
      tap_im[k] = 0;
      hist_re[k] = 0;
      hist_im[k] = 0;
    end
    win_energy = 0;
    tap_energy_q = 0;
    wptr = 0;
    fill = 0;

    rows = '{
      '{ROW_CFG, nsx_pkg::FUNC_LOAD, 0, 0, 0, 64'd0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_LOAD, 0, 32767, -32768, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_LOAD, 1023, -32768, 32767, 0, 0, none},
      '{ROW_LOAD_ALL, nsx_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, none},
      '{ROW_FILL, nsx_pkg::FUNC_PUSH, 0, 0, 0, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, 0, 0, 0, 1, zero_res},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, 32767, -32768, 0, 1, zero_res},
      '{ROW_CFG, nsx_pkg::FUNC_LOAD, 0, 0, 0, 64'd1, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, -32768, -32768, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, 32767, 32767, 0, 0, none},
      '{ROW_CFG, nsx_pkg::FUNC_LOAD, 0, 0, 0, 64'(TAP_E_MAX), 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, 1, -1, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, -32768, 32767, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_LOAD, 512, 0, 0, 0, 0, none},
      '{ROW_CFG_TAPS, nsx_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, 100, -100, 0, 0, none},
      '{ROW_ITEM, nsx_pkg::FUNC_PUSH, 0, -32768, 0, 0, 0, none}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_ITEM: begin
          send_item(rows[i].func, rows[i].idx, rows[i].re, rows[i].im, rows[i].typed,
                    rows[i].res);
        end
        ROW_CFG: begin
          write_tap_energy(rows[i].cfg);
        end
        ROW_CFG_TAPS: begin
          write_tap_energy(64'(loaded_tap_energy()));
        end
        ROW_LOAD_ALL: begin
          for (int k = 1; k < WIN - 1; k++)
            send_item(nsx_pkg::FUNC_LOAD, k, $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 65535) - 32768, 0, none);
        end
        ROW_FILL: begin
          for (int k = 0; k < WIN - 1; k++) send_item(nsx_pkg::FUNC_PUSH, 0, 0, 0, 0, none);
        end
      endcase
    end

    for (int n = 0; n < 540; n++) begin
      if (n % 120 == 119) begin
        pick = $urandom_range(0, 5);
        if (pick == 0) write_tap_energy(64'd1);
        else if (pick == 1) write_tap_energy(64'(TAP_E_MAX));
        else if (pick == 2) write_tap_energy(64'($urandom_range(1, 1 << 30)));
        else write_tap_energy(64'(loaded_tap_energy()));
      end
      if (n == 480) no_idle = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_item(nsx_pkg::FUNC_LOAD, $urandom_range(0, WIN - 1),
                  $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768, 0, none);
      end else if ($urandom_range(0, 3) == 0) begin
        send_item(nsx_pkg::FUNC_PUSH, $urandom_range(0, WIN - 1),
                  $urandom_range(0, 512) - 256,
                  $urandom_range(0, 512) - 256, 0, none);
      end else begin
        send_item(nsx_pkg::FUNC_PUSH, $urandom_range(0, WIN - 1),
                  $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768, 0, none);
      end
    end
    in_valid <= 1'b0;
    wait (corr_q.size() == 0);
    repeat (1300) @(posedge clk);
    if (errors == 0 && corr_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### filelist.f
design/nsx_pkg.sv
design/nsx_ctrl.sv
design/nsx_dp.sv
design/normalized_sliding_xcorr.sv
tb/sv/normalized_sliding_xcorr_tb.sv
